// File: hdl/mwm_pkg.sv
package mwm_pkg;

    localparam int MAX_WIDTH  = 16;
    localparam int MAX_HEIGHT = 16;

    localparam int POS_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int COORD_W    = 9;
    localparam int CELL_W     = 9;
    localparam int CELL_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

    // cell layout: visited, then known mask, then present mask
    localparam int VISITED_BIT = 0;
    localparam int KNOWN_LSB   = 1;
    localparam int PRESENT_LSB = 5;

    localparam logic [1:0] HEAD_NORTH = 2'd0;
    localparam logic [1:0] HEAD_EAST  = 2'd1;
    localparam logic [1:0] HEAD_SOUTH = 2'd2;
    localparam logic [1:0] HEAD_WEST  = 2'd3;

    // request kinds carried in req_type
    localparam logic [2:0] REQ_RESTART = 3'd0;
    localparam logic [2:0] REQ_MOTION  = 3'd1;
    localparam logic [2:0] REQ_WALL    = 3'd2;
    localparam logic [2:0] REQ_VISIT   = 3'd3;
    localparam logic [2:0] REQ_POSE    = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    // robot action codes
    localparam logic [3:0] ACT_NONE      = 4'd0;
    localparam logic [3:0] ACT_ADVANCE   = 4'd1;
    localparam logic [3:0] ACT_APPROACH  = 4'd2;
    localparam logic [3:0] ACT_SMOOTH_L  = 4'd3;
    localparam logic [3:0] ACT_SMOOTH_R  = 4'd4;
    localparam logic [3:0] ACT_PIVOT_L   = 4'd5;
    localparam logic [3:0] ACT_PIVOT_R   = 4'd6;
    localparam logic [3:0] ACT_PIVOT_180 = 4'd7;
    localparam logic [3:0] ACT_SNAPSHOT  = 4'd8;

    // configuration register indexes
    localparam logic [2:0] CFG_GRID_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_START_COLUMN  = 3'd2;
    localparam logic [2:0] CFG_START_ROW     = 3'd3;
    localparam logic [2:0] CFG_START_HEADING = 3'd4;

    typedef struct packed {
        logic               enabled;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } grid_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      in_bounds;
        logic [ADDR_W-1:0]         addr;
    } step_res_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [3:0]        action_code;
        logic              front_wall;
        logic              left_wall;
        logic              right_wall;
        logic signed [7:0] query_x;
        logic signed [7:0] query_y;
        logic [1:0]        query_heading;
    } req_t;

    typedef struct packed {
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [1:0]  heading;
        logic        cell_valid;
        logic        cell_visited;
        logic [3:0]  cell_walls_known;
        logic [3:0]  cell_walls_present;
        logic [31:0] pose_updates;
        logic [31:0] wall_updates;
        logic [3:0]  last_pose_action;
        logic [3:0]  last_wall_action;
    } rsp_t;

endpackage

// File: hdl/mwm_step_unit.sv
module mwm_step_unit (
    input  logic signed [mwm_pkg::COORD_W-1:0] x,
    input  logic signed [mwm_pkg::COORD_W-1:0] y,
    input  logic [1:0]                         dir,
    input  logic                               step,
    input  mwm_pkg::grid_t                     grid,
    output mwm_pkg::step_res_t                 res
);
    import mwm_pkg::*;

    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic [COORD_W-1:0]        ux;
    logic [COORD_W-1:0]        uy;

    // advance one cell along dir when step is set
    always_comb
    begin
        nx = x;
        ny = y;
        if (step)
        begin
            case (dir)
                HEAD_NORTH: ny = y - COORD_W'(1);
                HEAD_EAST:  nx = x + COORD_W'(1);
                HEAD_SOUTH: ny = y + COORD_W'(1);
                default:    nx = x - COORD_W'(1);
            endcase
        end
    end

    assign ux = $unsigned(nx);
    assign uy = $unsigned(ny);

    assign res.x         = nx;
    assign res.y         = ny;
    assign res.in_bounds = grid.enabled && !nx[COORD_W-1] && !ny[COORD_W-1]
                           && (ux < COORD_W'(grid.width)) && (uy < COORD_W'(grid.height));
    assign res.addr      = ADDR_W'(uy * MAX_WIDTH + ux);

endmodule

// File: hdl/mwm_cell_store.sv
module mwm_cell_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        rd_en,
    input  logic [mwm_pkg::ADDR_W-1:0]  rd_addr,
    input  logic                        wr_en,
    input  logic [mwm_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [mwm_pkg::CELL_W-1:0]  wr_data,
    output logic [mwm_pkg::CELL_W-1:0]  rd_data
);
    import mwm_pkg::*;

    logic [CELL_W-1:0]     mem [CELL_DEPTH];
    logic [CELL_DEPTH-1:0] valid_reg;
    logic [CELL_DEPTH-1:0] valid_next;
    logic [CELL_W-1:0]     data_reg;
    logic                  hit_reg;

    // drop every entry at once on clear; an entry not yet written reads as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

// File: hdl/maze_wall_map_pose_tracker.sv
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+---------------------------------------
// request   | start, busy, request (req_t)        | taken at an edge with start & !busy
// result    | done, result (rsp_t)                | done high one cycle, cannot be held off
// config    | cfg_wr_en, cfg_index, cfg_data      | written at an edge with cfg_wr_en high
//
// One transaction runs from accept to the done strobe through EXEC, REPORT_RD and REPORT
// for a motion, set pose, read cell or ignored request. Restart, mark visited and a wall
// update add RMW_RD then RMW_WR per cell touch, a read-modify-write through the cell store,
// up to six of them. busy stays high until the result is registered.
// Reset is asynchronous, active low; the map stays disabled until the first restart.
// Restart drops the whole cell store at once through its per-entry valid bits.
module maze_wall_map_pose_tracker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mwm_pkg::req_t request,
    output logic          done,
    output mwm_pkg::rsp_t result,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [7:0]    cfg_data
);
    import mwm_pkg::*;

    localparam logic [2:0] LAST_WALL_STEP = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_EXEC      = 6'b000010,
        ST_RMW_RD    = 6'b000100,
        ST_RMW_WR    = 6'b001000,
        ST_REPORT_RD = 6'b010000,
        ST_REPORT    = 6'b100000
    } state_t;

    function automatic logic [SIZE_W-1:0] size_clamp(input logic [7:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == 8'd0)
        begin
            r = SIZE_W'(1);
        end
        else if ({1'b0, v} > 9'(maxv))
        begin
            r = maxv;
        end
        else
        begin
            r = SIZE_W'(v);
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pos_clamp(input logic signed [7:0] v,
                                                   input logic [SIZE_W-1:0] size);
        logic [POS_W-1:0] r;
        logic [SIZE_W-1:0] diff;
        diff = size - SIZE_W'(1);
        if (v[7])
        begin
            r = '0;
        end
        else if (SIZE_W'(v[6:0]) >= size)
        begin
            r = diff[POS_W-1:0];
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [2:0]        sub_reg, sub_next;
    logic              rpt_valid_reg, rpt_valid_next;

    logic              enabled_reg, enabled_next;
    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    logic [POS_W-1:0]  x_reg, x_next;
    logic [POS_W-1:0]  y_reg, y_next;
    logic [1:0]        head_reg, head_next;
    logic [31:0]       pose_cnt_reg, pose_cnt_next;
    logic [31:0]       wall_cnt_reg, wall_cnt_next;
    logic [3:0]        last_pose_reg, last_pose_next;
    logic [3:0]        last_wall_reg, last_wall_next;

    logic [7:0]        cfg_width_reg;
    logic [7:0]        cfg_height_reg;
    logic [7:0]        cfg_col_reg;
    logic [7:0]        cfg_row_reg;
    logic [1:0]        cfg_head_reg;

    rsp_t              result_reg, result_next;
    logic              done_reg, done_next;

    grid_t                     grid;
    logic signed [COORD_W-1:0] unit_x;
    logic signed [COORD_W-1:0] unit_y;
    logic [1:0]                unit_dir;
    logic                      unit_step;
    step_res_t                 unit_res;

    logic              store_clear;
    logic              store_rd_en;
    logic              store_wr_en;
    logic [CELL_W-1:0] store_wr_data;
    logic [CELL_W-1:0] store_rd_data;

    // wall sequencing: step bits [2:1] pick front/left/right, bit 0 picks own cell or neighbor
    logic [1:0]        wall_dir;
    logic [1:0]        bit_dir;
    logic              wall_present;
    logic              is_wall_op;
    logic [1:0]        turn_head;
    logic [SIZE_W-1:0] new_width;
    logic [SIZE_W-1:0] new_height;

    assign grid.enabled = enabled_reg;
    assign grid.width   = width_reg;
    assign grid.height  = height_reg;

    assign is_wall_op = (req_reg.req_type == REQ_WALL);

    always_comb
    begin
        case (sub_reg[2:1])
            2'd0:
            begin
                wall_dir     = head_reg;
                wall_present = req_reg.front_wall;
            end
            2'd1:
            begin
                wall_dir     = head_reg + 2'd3;
                wall_present = req_reg.left_wall;
            end
            default:
            begin
                wall_dir     = head_reg + 2'd1;
                wall_present = req_reg.right_wall;
            end
        endcase
        bit_dir = sub_reg[0] ? (wall_dir + 2'd2) : wall_dir;
    end

    // heading after the turn part of a motion action
    always_comb
    begin
        case (req_reg.action_code)
            ACT_SMOOTH_L, ACT_PIVOT_L: turn_head = head_reg + 2'd3;
            ACT_SMOOTH_R, ACT_PIVOT_R: turn_head = head_reg + 2'd1;
            ACT_PIVOT_180:             turn_head = head_reg + 2'd2;
            default:                   turn_head = head_reg;
        endcase
    end

    assign new_width  = size_clamp(cfg_width_reg, SIZE_W'(MAX_WIDTH));
    assign new_height = size_clamp(cfg_height_reg, SIZE_W'(MAX_HEIGHT));

    // feed the shared stepping unit for whatever the sequencer is doing now
    always_comb
    begin
        unit_x    = COORD_W'(x_reg);
        unit_y    = COORD_W'(y_reg);
        unit_dir  = head_reg;
        unit_step = 1'b0;
        case (state_reg)
            ST_EXEC:
            begin
                unit_dir  = turn_head;
                unit_step = 1'b1;
            end
            ST_RMW_RD, ST_RMW_WR:
            begin
                unit_dir  = wall_dir;
                unit_step = is_wall_op && sub_reg[0];
            end
            ST_REPORT_RD:
            begin
                if (req_reg.req_type == REQ_READ)
                begin
                    unit_x = COORD_W'(req_reg.query_x);
                    unit_y = COORD_W'(req_reg.query_y);
                end
            end
            default:
            begin
                unit_step = 1'b0;
            end
        endcase
    end

    mwm_step_unit u_step (
        .x    (unit_x),
        .y    (unit_y),
        .dir  (unit_dir),
        .step (unit_step),
        .grid (grid),
        .res  (unit_res)
    );

    mwm_cell_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (store_clear),
        .rd_en   (store_rd_en),
        .rd_addr (unit_res.addr),
        .wr_en   (store_wr_en),
        .wr_addr (unit_res.addr),
        .wr_data (store_wr_data),
        .rd_data (store_rd_data)
    );

    // modify the cell read back in the previous cycle
    always_comb
    begin
        store_wr_data = store_rd_data;
        if (is_wall_op)
        begin
            store_wr_data[KNOWN_LSB + int'(bit_dir)]   = 1'b1;
            store_wr_data[PRESENT_LSB + int'(bit_dir)] = wall_present;
        end
        else
        begin
            store_wr_data[VISITED_BIT] = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        sub_next       = sub_reg;
        rpt_valid_next = rpt_valid_reg;
        enabled_next   = enabled_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        head_next      = head_reg;
        pose_cnt_next  = pose_cnt_reg;
        wall_cnt_next  = wall_cnt_reg;
        last_pose_next = last_pose_reg;
        last_wall_next = last_wall_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        store_clear    = 1'b0;
        store_rd_en    = 1'b0;
        store_wr_en    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    sub_next   = '0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_REPORT_RD;
                if (req_reg.req_type == REQ_RESTART)
                begin
                    // clear the map, size the grid, place the start pose, then mark it
                    store_clear    = 1'b1;
                    enabled_next   = 1'b1;
                    width_next     = new_width;
                    height_next    = new_height;
                    x_next         = pos_clamp(cfg_col_reg, new_width);
                    y_next         = pos_clamp(cfg_row_reg, new_height);
                    head_next      = cfg_head_reg;
                    pose_cnt_next  = '0;
                    wall_cnt_next  = '0;
                    last_pose_next = '0;
                    last_wall_next = '0;
                    state_next     = ST_RMW_RD;
                end
                else if (enabled_reg)
                begin
                    case (req_reg.req_type)
                        REQ_MOTION:
                        begin
                            head_next = turn_head;
                            if ((req_reg.action_code inside
                                    {ACT_ADVANCE, ACT_SMOOTH_L, ACT_SMOOTH_R})
                                && unit_res.in_bounds)
                            begin
                                x_next = unit_res.x[POS_W-1:0];
                                y_next = unit_res.y[POS_W-1:0];
                            end
                            if ((x_next != x_reg) || (y_next != y_reg)
                                || (head_next != head_reg))
                            begin
                                last_pose_next = req_reg.action_code;
                                pose_cnt_next  = pose_cnt_reg + 32'd1;
                            end
                        end
                        REQ_WALL:
                        begin
                            last_wall_next = req_reg.action_code;
                            wall_cnt_next  = wall_cnt_reg + 32'd1;
                            state_next     = ST_RMW_RD;
                        end
                        REQ_VISIT:
                        begin
                            state_next = ST_RMW_RD;
                        end
                        REQ_POSE:
                        begin
                            x_next    = pos_clamp(req_reg.query_x, width_reg);
                            y_next    = pos_clamp(req_reg.query_y, height_reg);
                            head_next = req_reg.query_heading;
                        end
                        default:
                        begin
                            state_next = ST_REPORT_RD;
                        end
                    endcase
                end
            end

            ST_RMW_RD:
            begin
                if (unit_res.in_bounds)
                begin
                    store_rd_en = 1'b1;
                    state_next  = ST_RMW_WR;
                end
                else if (sub_reg == LAST_WALL_STEP)
                begin
                    // drop a mirror bit that falls outside the grid
                    state_next = ST_REPORT_RD;
                end
                else
                begin
                    sub_next = sub_reg + 3'd1;
                end
            end

            ST_RMW_WR:
            begin
                store_wr_en = 1'b1;
                if (is_wall_op && (sub_reg != LAST_WALL_STEP))
                begin
                    sub_next   = sub_reg + 3'd1;
                    state_next = ST_RMW_RD;
                end
                else
                begin
                    state_next = ST_REPORT_RD;
                end
            end

            ST_REPORT_RD:
            begin
                store_rd_en    = 1'b1;
                rpt_valid_next = unit_res.in_bounds;
                state_next     = ST_REPORT;
            end

            ST_REPORT:
            begin
                result_next.pos_x              = x_reg;
                result_next.pos_y              = y_reg;
                result_next.heading            = head_reg;
                result_next.cell_valid         = rpt_valid_reg;
                result_next.cell_visited       = rpt_valid_reg
                                                 & store_rd_data[VISITED_BIT];
                result_next.cell_walls_known   = rpt_valid_reg
                                                 ? store_rd_data[KNOWN_LSB +: 4] : 4'd0;
                result_next.cell_walls_present = rpt_valid_reg
                                                 ? store_rd_data[PRESENT_LSB +: 4] : 4'd0;
                result_next.pose_updates       = pose_cnt_reg;
                result_next.wall_updates       = wall_cnt_reg;
                result_next.last_pose_action   = last_pose_reg;
                result_next.last_wall_action   = last_wall_reg;
                done_next                      = 1'b1;
                state_next                     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sub_reg        <= '0;
            rpt_valid_reg  <= 1'b0;
            enabled_reg    <= 1'b0;
            width_reg      <= SIZE_W'(1);
            height_reg     <= SIZE_W'(1);
            x_reg          <= '0;
            y_reg          <= '0;
            head_reg       <= HEAD_NORTH;
            pose_cnt_reg   <= '0;
            wall_cnt_reg   <= '0;
            last_pose_reg  <= '0;
            last_wall_reg  <= '0;
            done_reg       <= 1'b0;
            cfg_width_reg  <= 8'd16;
            cfg_height_reg <= 8'd16;
            cfg_col_reg    <= 8'd0;
            cfg_row_reg    <= 8'd0;
            cfg_head_reg   <= HEAD_NORTH;
        end
        else
        begin
            state_reg     <= state_next;
            sub_reg       <= sub_next;
            rpt_valid_reg <= rpt_valid_next;
            enabled_reg   <= enabled_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            head_reg      <= head_next;
            pose_cnt_reg  <= pose_cnt_next;
            wall_cnt_reg  <= wall_cnt_next;
            last_pose_reg <= last_pose_next;
            last_wall_reg <= last_wall_next;
            done_reg      <= done_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:    cfg_width_reg  <= cfg_data;
                    CFG_GRID_HEIGHT:   cfg_height_reg <= cfg_data;
                    CFG_START_COLUMN:  cfg_col_reg    <= cfg_data;
                    CFG_START_ROW:     cfg_row_reg    <= cfg_data;
                    CFG_START_HEADING: cfg_head_reg   <= cfg_data[1:0];
                    default:           cfg_head_reg   <= cfg_head_reg;
                endcase
            end
        end
    end

    // payload registers: hold the request and the result without reset
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: test/tb_maze_wall_map_pose_tracker.sv
`timescale 1ns / 100ps

module tb_maze_wall_map_pose_tracker;
    import mwm_pkg::*;

    // Request kinds with no meaning to the block
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    // Action codes outside the defined set
    localparam logic [3:0] ACT_UNDEFINED_LO = 4'd9;
    localparam logic [3:0] ACT_UNDEFINED_HI = 4'd15;

    // Longest quiet stretch: a sender gap plus a wall update plus drain margin
    localparam int QUIET_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    req_t       request = '0;
    logic       done;
    rsp_t       result;
    logic       cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    maze_wall_map_pose_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Map and pose predictor: our own copy of the registers and state
    // ------------------------------------------------------------------
    logic [7:0]        cfg_cols  = 8'd16;
    logic [7:0]        cfg_rows  = 8'd16;
    logic signed [7:0] cfg_col0  = '0;
    logic signed [7:0] cfg_row0  = '0;
    logic [1:0]        cfg_head0 = HEAD_NORTH;

    bit                map_on = 1'b0;
    int                grid_w = 1;
    int                grid_h = 1;
    int                pose_x = 0;
    int                pose_y = 0;
    logic [1:0]        pose_hd = HEAD_NORTH;
    logic [CELL_W-1:0] cell_map [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    logic [31:0]       moves_seen = '0;
    logic [31:0]       walls_seen = '0;
    logic [3:0]        pose_tag = '0;
    logic [3:0]        wall_tag = '0;

    rsp_t predicted_reports [$];
    int   mismatches = 0;
    int   idle_pct = 0;
    int   quiet_cycles = 0;

    initial
    begin
        foreach (cell_map[i, j]) cell_map[i][j] = '0;
    end

    function automatic bit in_grid(int x, int y);
        return map_on && x >= 0 && y >= 0 && x < grid_w && y < grid_h;
    endfunction

    function automatic int clamp_pos(int v, int size);
        if (v < 0) return 0;
        if (v >= size) return size - 1;
        return v;
    endfunction

    function automatic int nudge_x(int x, logic [1:0] dir);
        if (dir == HEAD_EAST) return x + 1;
        if (dir == HEAD_WEST) return x - 1;
        return x;
    endfunction

    // North is one row up
    function automatic int nudge_y(int y, logic [1:0] dir);
        if (dir == HEAD_NORTH) return y - 1;
        if (dir == HEAD_SOUTH) return y + 1;
        return y;
    endfunction

    function automatic void move_ahead();
        int nx;
        int ny;
        nx = nudge_x(pose_x, pose_hd);
        ny = nudge_y(pose_y, pose_hd);
        // Hold the pose when the step would leave the grid
        if (in_grid(nx, ny))
        begin
            pose_x = nx;
            pose_y = ny;
        end
    endfunction

    function automatic void mark_wall(int x, int y, logic [1:0] dir, logic present);
        cell_map[y][x][KNOWN_LSB + dir]   = 1'b1;
        cell_map[y][x][PRESENT_LSB + dir] = present;
    endfunction

    // Write one wall into the current cell and its mirror into the neighbor, if inside
    function automatic void record_wall(logic [1:0] dir, logic present);
        int         nx;
        int         ny;
        logic [1:0] back;
        if (!in_grid(pose_x, pose_y)) return;
        mark_wall(pose_x, pose_y, dir, present);
        nx   = nudge_x(pose_x, dir);
        ny   = nudge_y(pose_y, dir);
        back = dir + 2'd2;
        if (in_grid(nx, ny)) mark_wall(nx, ny, back, present);
    endfunction

    // Advance the predicted state by one request and build the status it reports
    function automatic rsp_t predict_report(req_t r);
        rsp_t              rsp;
        int                qx;
        int                qy;
        int                rx;
        int                ry;
        int                x0;
        int                y0;
        logic [1:0]        h0;
        logic [1:0]        left_dir;
        logic [1:0]        right_dir;
        logic [CELL_W-1:0] cell_bits;
        bit                valid;

        qx = int'(r.query_x);
        qy = int'(r.query_y);

        if (r.req_type == REQ_RESTART)
        begin
            foreach (cell_map[i, j]) cell_map[i][j] = '0;
            map_on  = 1'b1;
            grid_w  = (cfg_cols == 0) ? 1 : (cfg_cols > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_cols);
            grid_h  = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_rows);
            pose_x  = clamp_pos(int'(cfg_col0), grid_w);
            pose_y  = clamp_pos(int'(cfg_row0), grid_h);
            pose_hd = cfg_head0;
            cell_map[pose_y][pose_x][VISITED_BIT] = 1'b1;
            moves_seen = '0;
            walls_seen = '0;
            pose_tag   = '0;
            wall_tag   = '0;
        end
        else if (map_on)
        begin
            case (r.req_type)
                REQ_MOTION:
                begin
                    x0 = pose_x;
                    y0 = pose_y;
                    h0 = pose_hd;
                    case (r.action_code)
                        ACT_ADVANCE: move_ahead();
                        ACT_SMOOTH_L:
                        begin
                            pose_hd = pose_hd - 2'd1;
                            move_ahead();
                        end
                        ACT_SMOOTH_R:
                        begin
                            pose_hd = pose_hd + 2'd1;
                            move_ahead();
                        end
                        ACT_PIVOT_L:   pose_hd = pose_hd - 2'd1;
                        ACT_PIVOT_R:   pose_hd = pose_hd + 2'd1;
                        ACT_PIVOT_180: pose_hd = pose_hd + 2'd2;
                        default: ;
                    endcase
                    // Count only actions that really changed the pose
                    if (pose_x != x0 || pose_y != y0 || pose_hd != h0)
                    begin
                        pose_tag   = r.action_code;
                        moves_seen = moves_seen + 32'd1;
                    end
                end
                REQ_WALL:
                begin
                    if (in_grid(pose_x, pose_y))
                    begin
                        left_dir  = pose_hd + 2'd3;
                        right_dir = pose_hd + 2'd1;
                        record_wall(pose_hd, r.front_wall);
                        record_wall(left_dir, r.left_wall);
                        record_wall(right_dir, r.right_wall);
                        wall_tag   = r.action_code;
                        walls_seen = walls_seen + 32'd1;
                    end
                end
                REQ_VISIT:
                begin
                    if (in_grid(pose_x, pose_y)) cell_map[pose_y][pose_x][VISITED_BIT] = 1'b1;
                end
                REQ_POSE:
                begin
                    pose_x  = clamp_pos(qx, grid_w);
                    pose_y  = clamp_pos(qy, grid_h);
                    pose_hd = r.query_heading;
                end
                default: ;
            endcase
        end

        rx        = (r.req_type == REQ_READ) ? qx : pose_x;
        ry        = (r.req_type == REQ_READ) ? qy : pose_y;
        valid     = in_grid(rx, ry);
        cell_bits = valid ? cell_map[ry][rx] : '0;

        rsp.pos_x              = 6'(pose_x);
        rsp.pos_y              = 6'(pose_y);
        rsp.heading            = pose_hd;
        rsp.cell_valid         = valid;
        rsp.cell_visited       = cell_bits[VISITED_BIT];
        rsp.cell_walls_known   = cell_bits[KNOWN_LSB +: 4];
        rsp.cell_walls_present = cell_bits[PRESENT_LSB +: 4];
        rsp.pose_updates       = moves_seen;
        rsp.wall_updates       = walls_seen;
        rsp.last_pose_action   = pose_tag;
        rsp.last_wall_action   = wall_tag;
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what);
        mismatches++;
        $display("%0t ns  mismatch: %s", $time, what);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task automatic check_report(rsp_t got);
        rsp_t want;
        if (predicted_reports.size() == 0)
        begin
            report_mismatch("result strobe with no transaction outstanding");
            return;
        end
        want = predicted_reports.pop_front();
        compare_field("pos_x", 32'(got.pos_x), 32'(want.pos_x));
        compare_field("pos_y", 32'(got.pos_y), 32'(want.pos_y));
        compare_field("heading", 32'(got.heading), 32'(want.heading));
        compare_field("cell_valid", 32'(got.cell_valid), 32'(want.cell_valid));
        compare_field("cell_visited", 32'(got.cell_visited), 32'(want.cell_visited));
        compare_field("cell_walls_known", 32'(got.cell_walls_known),
                      32'(want.cell_walls_known));
        compare_field("cell_walls_present", 32'(got.cell_walls_present),
                      32'(want.cell_walls_present));
        compare_field("pose_updates", got.pose_updates, want.pose_updates);
        compare_field("wall_updates", got.wall_updates, want.wall_updates);
        compare_field("last_pose_action", 32'(got.last_pose_action),
                      32'(want.last_pose_action));
        compare_field("last_wall_action", 32'(got.last_wall_action),
                      32'(want.last_wall_action));
    endtask

    // Sample the strobe at the edge that ends its cycle; the receiver never stalls
    always @(posedge clk)
    begin
        if (rst_n && done) check_report(result);
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_maze_wall_map_pose_tracker: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic req_t make_req(logic [2:0] kind, logic [3:0] act,
                                      logic fw, logic lw, logic rw,
                                      logic [7:0] qx, logic [7:0] qy, logic [1:0] qh);
        req_t r;
        r.req_type      = kind;
        r.action_code   = act;
        r.front_wall    = fw;
        r.left_wall     = lw;
        r.right_wall    = rw;
        r.query_x       = qx;
        r.query_y       = qy;
        r.query_heading = qh;
        return r;
    endfunction

    // Present one transaction and hold it until taken. Unless an idle gap follows, leave start
    // high on return so a back-to-back transaction never drops and raises it in the same step.
    task automatic send_req(req_t r);
        int gap;
        request <= r;
        start   <= 1'b1;
        do @(posedge clk); while (busy);
        predicted_reports.push_back(predict_report(r));
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 20);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every predicted report has come back
    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge clk); while (predicted_reports.size() != 0 || busy);
    endtask

    // Leave the write enable high; configure lowers it once after the last write
    task automatic write_reg(logic [2:0] idx, logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_GRID_WIDTH:    cfg_cols  = data;
            CFG_GRID_HEIGHT:   cfg_rows  = data;
            CFG_START_COLUMN:  cfg_col0  = data;
            CFG_START_ROW:     cfg_row0  = data;
            CFG_START_HEADING: cfg_head0 = data[1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [7:0] cols, logic [7:0] rows, logic [7:0] col0,
                             logic [7:0] row0, logic [1:0] head0);
        wait_quiet();
        write_reg(CFG_GRID_WIDTH, cols);
        write_reg(CFG_GRID_HEIGHT, rows);
        write_reg(CFG_START_COLUMN, col0);
        write_reg(CFG_START_ROW, row0);
        write_reg(CFG_START_HEADING, {6'd0, head0});
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before any restart the map is off: every request is dropped, the cell is invalid
    task automatic test_disabled_map();
        idle_pct = 0;
        send_req(make_req(REQ_MOTION, ACT_ADVANCE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_WALL, ACT_PIVOT_L, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_POSE, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd3, 8'd4, HEAD_EAST));
        send_req(make_req(REQ_READ, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_SPARE6, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
    endtask

    // One-column and one-row grids with start registers at their signed extremes
    task automatic test_grid_corners();
        idle_pct = 0;
        // Width 0 clamps to 1, height 255 to the maximum; start clamps to (0, last row)
        configure(8'd0, 8'd255, 8'h80, 8'h7f, HEAD_WEST);
        send_req(make_req(REQ_RESTART, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        // Step off the west edge: nothing happens
        send_req(make_req(REQ_MOTION, ACT_ADVANCE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_MOTION, ACT_SMOOTH_R, 1'b0, 1'b0, 1'b0,
                          8'd0, 8'd0, HEAD_NORTH));
        // Side mirrors fall outside the single column and are dropped
        send_req(make_req(REQ_WALL, ACT_UNDEFINED_HI, 1'b1, 1'b1, 1'b1,
                          8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_READ, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd13, HEAD_NORTH));
        send_req(make_req(REQ_READ, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'h80, 8'h7f, HEAD_NORTH));
        send_req(make_req(REQ_POSE, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'h7f, 8'h80, HEAD_EAST));
        send_req(make_req(REQ_MOTION, ACT_PIVOT_180, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_VISIT, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_SPARE7, ACT_SNAPSHOT, 1'b1, 1'b1, 1'b1, 8'hff, 8'hff, HEAD_WEST));

        // Width 255 clamps to the maximum, height 0 to 1; start lands at the east end
        configure(8'd255, 8'd0, 8'h7f, 8'h80, HEAD_SOUTH);
        send_req(make_req(REQ_RESTART, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        // Codes that never move the robot leave the pose counter alone
        send_req(make_req(REQ_MOTION, ACT_SNAPSHOT, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_MOTION, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_MOTION, ACT_APPROACH, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_MOTION, ACT_UNDEFINED_LO, 1'b0, 1'b0, 1'b0,
                          8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_MOTION, ACT_PIVOT_L, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_MOTION, ACT_ADVANCE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        // Turn part only: the move north would leave the single row
        send_req(make_req(REQ_MOTION, ACT_SMOOTH_L, 1'b0, 1'b0, 1'b0,
                          8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_WALL, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_MOTION, ACT_PIVOT_R, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_WALL, ACT_SNAPSHOT, 1'b1, 1'b0, 1'b1, 8'd0, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_READ, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd14, 8'd0, HEAD_NORTH));
        send_req(make_req(REQ_READ, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd16, 8'd0, HEAD_NORTH));
    endtask

    // Random exploration of random grids: restart, then mostly well-formed robot
    // traffic around the grid edges, with a little noise from rare kinds and codes
    task automatic test_exploration(int pct);
        req_t r;
        int   kind;
        idle_pct = pct;
        repeat (2)
        begin
            configure(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                      2'($urandom));
            send_req(make_req(REQ_RESTART, ACT_NONE, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, HEAD_NORTH));
            repeat (240)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 2)       r.req_type = REQ_RESTART;
                else if (kind < 42) r.req_type = REQ_MOTION;
                else if (kind < 67) r.req_type = REQ_WALL;
                else if (kind < 75) r.req_type = REQ_VISIT;
                else if (kind < 83) r.req_type = REQ_POSE;
                else if (kind < 97) r.req_type = REQ_READ;
                else                r.req_type = ($urandom_range(0, 1) == 0) ? REQ_SPARE6
                                                                               : REQ_SPARE7;
                r.action_code = ($urandom_range(0, 9) == 0)
                              ? 4'($urandom_range(ACT_UNDEFINED_LO, ACT_UNDEFINED_HI))
                              : 4'($urandom_range(ACT_NONE, ACT_SNAPSHOT));
                r.front_wall = 1'($urandom);
                r.left_wall  = 1'($urandom);
                r.right_wall = 1'($urandom);
                // Aim queries at the grid and one cell beyond it, sometimes anywhere
                r.query_x = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, grid_w + 1) - 1);
                r.query_y = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, grid_h + 1) - 1);
                r.query_heading = 2'($urandom);
                send_req(r);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_map();
        test_grid_corners();
        test_exploration(0);
        test_exploration(69);
        test_exploration(7);

        // Drain, then give any stray strobe time to show up
        wait_quiet();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_maze_wall_map_pose_tracker: PASS");
        else
            $display("tb_maze_wall_map_pose_tracker: FAIL");
        $finish;
    end

endmodule
